FILE: src/vsa_pkg.sv
// shared types and constants for the voice slot allocator
package vsa_pkg;

  // fixed field widths
  localparam int CFG_W      = 5;
  localparam int REL_W      = 4;
  localparam int SLOT_OUT_W = 4;
  localparam int CNT_OUT_W  = 5;
  localparam int ST_W       = 2;

  // pool limit: reset value and floor
  localparam int LIMIT_RESET = 8;
  localparam int LIMIT_MIN   = 1;

  // operation codes
  localparam logic OP_ACQUIRE = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  // result status codes
  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_NO_OWNER  = 2'd1;
  localparam logic [ST_W-1:0] ST_NO_VICTIM = 2'd2;
  localparam logic [ST_W-1:0] ST_NOT_BUSY  = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic scan_start;
    logic scan_issue;
    logic commit;
  } vsa_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_scan;
    logic scan_last;
    logic pipe_busy;
    logic out_free;
  } vsa_stat_t;

endpackage

FILE: src/vsa_ctrl.sv
// sequencer for capture, furthest-slot scan and commit
module vsa_ctrl
  import vsa_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  vsa_stat_t stat,
  output vsa_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_COMMIT = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat.need_scan) begin
          cmd.scan_start = 1'b1;
          state_nxt      = S_SCAN;
        end else begin
          state_nxt = S_COMMIT;
        end
      end
      S_SCAN: begin
        cmd.scan_issue = 1'b1;
        if (stat.scan_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!stat.pipe_busy) begin
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: src/vsa_datapath.sv
// slot store, distance pipeline, victim tracking, commit logic and result register
module vsa_datapath
  import vsa_pkg::*;
#(
  parameter int SLOTS      = 16,
  parameter int COORD_BITS = 20
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  vsa_cmd_t                     cmd,
  output vsa_stat_t                    stat,
  input  logic                         cfg_wr_en,
  input  logic [CFG_W-1:0]             cfg_wr_data,
  input  logic                         in_operation,
  input  logic                         in_owner_present,
  input  logic signed [COORD_BITS-1:0] in_source_x,
  input  logic signed [COORD_BITS-1:0] in_source_y,
  input  logic signed [COORD_BITS-1:0] in_source_z,
  input  logic                         in_listener_present,
  input  logic signed [COORD_BITS-1:0] in_listener_x,
  input  logic signed [COORD_BITS-1:0] in_listener_y,
  input  logic signed [COORD_BITS-1:0] in_listener_z,
  input  logic [REL_W-1:0]             in_release_slot,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [ST_W-1:0]              out_status,
  output logic [SLOT_OUT_W-1:0]        out_granted_slot,
  output logic                         out_stole,
  output logic [SLOT_OUT_W-1:0]        out_stolen_slot,
  output logic [CNT_OUT_W-1:0]         out_busy_count
);

  localparam int CB      = COORD_BITS;
  localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W   = $clog2(SLOTS + 1);
  localparam int RX_W    = REL_W + SLOT_W;
  localparam int SQ_W    = 2 * CB;
  localparam int SUM_W   = SQ_W + 2;
  localparam int POS_W   = 3 * CB;
  localparam int RESET_LIMIT = (LIMIT_RESET > SLOTS) ? SLOTS : LIMIT_RESET;

  // captured word
  logic                 op_r, owner_r, lp_r;
  logic signed [CB-1:0] sx_r, sy_r, sz_r, lx_r, ly_r, lz_r;
  logic [REL_W-1:0]     rel_r;

  // pool state
  logic [SLOTS-1:0] busy_r;
  logic [CNT_W-1:0] total_r;
  logic [CNT_W-1:0] limit_r;
  logic [CNT_W-1:0] limit_cfg;
  logic [POS_W-1:0] pos_mem [SLOTS];

  // scan pipeline
  logic [SLOT_W-1:0]    scan_idx_r;
  logic                 v1_r, busy1_r;
  logic [SLOT_W-1:0]    idx1_r;
  logic [POS_W-1:0]     pos_q_r;
  logic                 v2_r, busy2_r;
  logic [SLOT_W-1:0]    idx2_r;
  logic [SQ_W-1:0]      sqx_r, sqy_r, sqz_r;
  logic [SUM_W-1:0]     best_r;
  logic [SLOT_W-1:0]    victim_r;
  logic                 found_r;
  logic signed [CB:0]   dx, dy, dz;
  logic [CB-1:0]        mx, my, mz;
  logic [SUM_W-1:0]     dist_sum;

  // commit
  logic                 full;
  logic [RX_W-1:0]      rel_ext;
  logic                 rel_in;
  logic [SLOT_W-1:0]    rel_idx;
  logic                 steal_ok;
  logic [SLOTS-1:0]     base_busy;
  logic                 free_found;
  logic [SLOT_W-1:0]    free_idx;
  logic [ST_W-1:0]      c_status;
  logic [SLOT_W-1:0]    c_granted;
  logic                 c_stole;
  logic [SLOT_W-1:0]    c_stolen;
  logic [SLOTS-1:0]     c_busy;
  logic [CNT_W-1:0]     c_total;
  logic                 c_take;

  // result register
  logic                  out_valid_r;
  logic [ST_W-1:0]       out_status_r;
  logic [SLOT_OUT_W-1:0] out_granted_r;
  logic                  out_stole_r;
  logic [SLOT_OUT_W-1:0] out_stolen_r;
  logic [CNT_OUT_W-1:0]  out_count_r;

  assign full = (total_r >= limit_r);

  assign stat.need_scan = (op_r == OP_ACQUIRE) && owner_r && lp_r && full;
  assign stat.scan_last = (scan_idx_r == SLOT_W'(SLOTS - 1));
  assign stat.pipe_busy = v1_r | v2_r;
  assign stat.out_free  = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r    <= in_operation;
      owner_r <= in_owner_present;
      lp_r    <= in_listener_present;
      sx_r    <= in_source_x;
      sy_r    <= in_source_y;
      sz_r    <= in_source_z;
      lx_r    <= in_listener_x;
      ly_r    <= in_listener_y;
      lz_r    <= in_listener_z;
      rel_r   <= in_release_slot;
    end
  end

  // limit clamp to 1..SLOTS
  always_comb begin
    if (cfg_wr_data == '0) begin
      limit_cfg = CNT_W'(LIMIT_MIN);
    end else if (32'(cfg_wr_data) > 32'(SLOTS)) begin
      limit_cfg = CNT_W'(SLOTS);
    end else begin
      limit_cfg = CNT_W'(cfg_wr_data);
    end
  end

  // position store
  always_ff @(posedge clk) begin
    if (cmd.commit && c_take) begin
      pos_mem[c_granted] <= {sx_r, sy_r, sz_r};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_issue) begin
      pos_q_r <= pos_mem[scan_idx_r];
    end
  end

  // distance per axis, magnitude fits CB bits
  always_comb begin
    dx = {pos_q_r[POS_W-1], pos_q_r[POS_W-1 -: CB]} - {lx_r[CB-1], lx_r};
    dy = {pos_q_r[2*CB-1], pos_q_r[2*CB-1 -: CB]} - {ly_r[CB-1], ly_r};
    dz = {pos_q_r[CB-1], pos_q_r[CB-1:0]} - {lz_r[CB-1], lz_r};
    mx = dx[CB] ? CB'(-dx) : CB'(dx);
    my = dy[CB] ? CB'(-dy) : CB'(dy);
    mz = dz[CB] ? CB'(-dz) : CB'(dz);
  end

  assign dist_sum = SUM_W'(sqx_r) + SUM_W'(sqy_r) + SUM_W'(sqz_r);

  always_ff @(posedge clk) begin
    busy1_r <= busy_r[scan_idx_r];
    idx1_r  <= scan_idx_r;
    busy2_r <= busy1_r;
    idx2_r  <= idx1_r;
    sqx_r   <= SQ_W'(mx) * SQ_W'(mx);
    sqy_r   <= SQ_W'(my) * SQ_W'(my);
    sqz_r   <= SQ_W'(mz) * SQ_W'(mz);
    if (cmd.scan_start) begin
      best_r <= '0;
    end else if (v2_r && busy2_r && (dist_sum > best_r)) begin
      best_r   <= dist_sum;
      victim_r <= idx2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r <= '0;
      v1_r       <= 1'b0;
      v2_r       <= 1'b0;
      found_r    <= 1'b0;
    end else begin
      v1_r <= cmd.scan_issue;
      v2_r <= v1_r;
      if (cmd.scan_start) begin
        scan_idx_r <= '0;
        found_r    <= 1'b0;
      end else begin
        if (cmd.scan_issue) begin
          scan_idx_r <= scan_idx_r + SLOT_W'(1);
        end
        if (v2_r && busy2_r && (dist_sum > best_r)) begin
          found_r <= 1'b1;
        end
      end
    end
  end

  // release index check
  assign rel_ext = RX_W'(rel_r);
  assign rel_in  = (rel_ext < RX_W'(SLOTS));
  assign rel_idx = rel_ext[SLOT_W-1:0];

  // pool with the victim removed
  assign steal_ok = lp_r && found_r;

  always_comb begin
    base_busy = busy_r;
    if (full && steal_ok) begin
      base_busy[victim_r] = 1'b0;
    end
  end

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (!free_found && !base_busy[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    c_status  = ST_OK;
    c_granted = '0;
    c_stole   = 1'b0;
    c_stolen  = '0;
    c_busy    = busy_r;
    c_total   = total_r;
    c_take    = 1'b0;
    if (op_r == OP_RELEASE) begin
      if (rel_in && busy_r[rel_idx]) begin
        c_busy[rel_idx] = 1'b0;
        c_total         = total_r - CNT_W'(1);
      end else begin
        c_status = ST_NOT_BUSY;
      end
    end else if (!owner_r) begin
      c_status = ST_NO_OWNER;
    end else if (full && !steal_ok) begin
      c_status = ST_NO_VICTIM;
    end else begin
      if (full) begin
        c_stole  = 1'b1;
        c_stolen = victim_r;
      end
      if (free_found) begin
        c_busy           = base_busy;
        c_busy[free_idx] = 1'b1;
        c_granted        = free_idx;
        c_take           = 1'b1;
        c_total          = full ? total_r : total_r + CNT_W'(1);
      end else begin
        c_status = ST_NO_VICTIM;
        c_busy   = base_busy;
        c_total  = full ? total_r - CNT_W'(1) : total_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= '0;
      total_r <= '0;
      limit_r <= CNT_W'(RESET_LIMIT);
    end else if (cfg_wr_en) begin
      busy_r  <= '0;
      total_r <= '0;
      limit_r <= limit_cfg;
    end else if (cmd.commit) begin
      busy_r  <= c_busy;
      total_r <= c_total;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status_r  <= c_status;
      out_granted_r <= SLOT_OUT_W'(c_granted);
      out_stole_r   <= c_stole;
      out_stolen_r  <= SLOT_OUT_W'(c_stolen);
      out_count_r   <= CNT_OUT_W'(c_total);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_granted_slot = out_granted_r;
  assign out_stole        = out_stole_r;
  assign out_stolen_slot  = out_stolen_r;
  assign out_busy_count   = out_count_r;

endmodule

FILE: src/voice_slot_allocator_furthest_steal.sv
// top level of the voice slot allocator with furthest-voice stealing
//
//  channel  direction  handshake            payload
//  in       input      in_valid / in_stall  operation, owner, source xyz, listener xyz, slot
//  out      output     out_valid/out_stall  status, granted slot, stole, stolen slot, count
//  cfg      input      cfg_wr_en            cfg_wr_data = pool limit, clears the pool
//
// a release, an acquire without owner, below the limit or without listener goes
//   through capture, decide and commit; the result register loads at commit
// an acquire at the limit with a listener scans every slot, one per cycle through a
//   registered read, a squaring register and a registered compare, then drains
// reset: pool empty, limit 8 clamped to SLOTS; positions are not cleared
// a word is accepted while the previous result still waits; commit holds while
//   out_stall keeps the result register full
module voice_slot_allocator_furthest_steal
  import vsa_pkg::*;
#(
  parameter int SLOTS      = 16,
  parameter int COORD_BITS = 20
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [CFG_W-1:0]             cfg_wr_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_operation,
  input  logic                         in_owner_present,
  input  logic signed [COORD_BITS-1:0] in_source_x,
  input  logic signed [COORD_BITS-1:0] in_source_y,
  input  logic signed [COORD_BITS-1:0] in_source_z,
  input  logic                         in_listener_present,
  input  logic signed [COORD_BITS-1:0] in_listener_x,
  input  logic signed [COORD_BITS-1:0] in_listener_y,
  input  logic signed [COORD_BITS-1:0] in_listener_z,
  input  logic [REL_W-1:0]             in_release_slot,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [ST_W-1:0]              out_status,
  output logic [SLOT_OUT_W-1:0]        out_granted_slot,
  output logic                         out_stole,
  output logic [SLOT_OUT_W-1:0]        out_stolen_slot,
  output logic [CNT_OUT_W-1:0]         out_busy_count
);

  // sequencer commands and datapath status
  vsa_cmd_t  cmd;
  vsa_stat_t stat;

  // state machine: idle, decide, scan, drain, commit
  vsa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // slot store, squared-distance pipeline and result register
  vsa_datapath #(
    .SLOTS      (SLOTS),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_operation        (in_operation),
    .in_owner_present    (in_owner_present),
    .in_source_x         (in_source_x),
    .in_source_y         (in_source_y),
    .in_source_z         (in_source_z),
    .in_listener_present (in_listener_present),
    .in_listener_x       (in_listener_x),
    .in_listener_y       (in_listener_y),
    .in_listener_z       (in_listener_z),
    .in_release_slot     (in_release_slot),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_granted_slot    (out_granted_slot),
    .out_stole           (out_stole),
    .out_stolen_slot     (out_stolen_slot),
    .out_busy_count      (out_busy_count)
  );

  // commit never overwrites a result that is still stalled
  a_commit_free : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid || !out_stall))
    else $error("commit while result register is held");

  // a failed word grants nothing and steals nothing
  a_fail_clean : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_OK)) |->
      ((out_granted_slot == '0) && !out_stole && (out_stolen_slot == '0)))
    else $error("failed word carries a grant or steal");

  // stealing only on an acquire that succeeded
  a_steal_ok : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stole) |-> (out_status == ST_OK))
    else $error("steal reported on a failed word");

  // busy count never exceeds the pool
  a_count_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_busy_count) <= 32'(SLOTS)))
    else $error("busy count beyond pool size");

  // a scan only starts from a captured word
  a_scan_after_capture : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_start |-> $past(cmd.capture))
    else $error("scan started without a captured word");

endmodule
